// ===== design/rdc_pkg.sv =====
// Shared types and constants for the radix digit converter.
// No dependencies; used by rdc_ctrl, rdc_datapath and the top level.
package rdc_pkg;

  localparam logic [3:0] RADIX_RESET  = 4'd10;
  localparam logic [3:0] BASE_DEFAULT = 4'd10;
  localparam logic [3:0] BASE_MIN     = 4'd2;
  localparam logic [3:0] BASE_MAX     = 4'd9;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_READ,
    S_OUT
  } ctrl_state_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic pop;
  } dp_cmd_t;

  typedef struct packed {
    logic in_neg;
    logic neg;
    logic step_last;
    logic quo_zero;
    logic empty;
  } dp_stat_t;

  function automatic logic [3:0] eff_base(input logic [3:0] r);
    logic [3:0] b;
    if (r >= BASE_MIN && r <= BASE_MAX) begin
      b = r;
    end else begin
      b = BASE_DEFAULT;
    end
    return b;
  endfunction

endpackage

// ===== design/rdc_ctrl.sv =====
// Controller state machine for the radix digit converter.
// Depends on rdc_pkg; drives rdc_datapath through command/status structs.
module rdc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  rdc_pkg::dp_stat_t stat,
  output rdc_pkg::dp_cmd_t  cmd
);

  rdc_pkg::ctrl_state_t state;
  rdc_pkg::ctrl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rdc_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      rdc_pkg::S_IDLE: begin
        if (in_valid) begin
          state_next = stat.in_neg ? rdc_pkg::S_OUT : rdc_pkg::S_DIV;
        end
      end
      rdc_pkg::S_DIV: begin
        if (stat.step_last && stat.quo_zero) begin
          state_next = rdc_pkg::S_READ;
        end
      end
      rdc_pkg::S_READ: begin
        state_next = rdc_pkg::S_OUT;
      end
      rdc_pkg::S_OUT: begin
        if (!out_stall) begin
          state_next = (stat.neg || stat.empty) ? rdc_pkg::S_IDLE : rdc_pkg::S_READ;
        end
      end
      default: begin
        state_next = rdc_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall     = 1'b1;
    out_valid    = 1'b0;
    cmd.load     = 1'b0;
    cmd.div_step = 1'b0;
    cmd.pop      = 1'b0;
    case (state)
      rdc_pkg::S_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      rdc_pkg::S_DIV: begin
        cmd.div_step = 1'b1;
      end
      rdc_pkg::S_READ: begin
        cmd.pop = 1'b1;
      end
      rdc_pkg::S_OUT: begin
        out_valid = 1'b1;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

// ===== design/rdc_datapath.sv =====
// Datapath: radix register, bit-serial divider by the base, digit stack.
// Depends on rdc_pkg; controlled by rdc_ctrl.
module rdc_datapath #(
  parameter int VALUE_BITS = 31
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [3:0]        cfg_wr_data,
  input  logic [31:0]       value,
  input  rdc_pkg::dp_cmd_t  cmd,
  output rdc_pkg::dp_stat_t stat,
  output logic [3:0]        digit,
  output logic              last_digit,
  output logic              invalid
);

  localparam int CntW  = $clog2(VALUE_BITS + 1);
  localparam int IdxW  = $clog2(VALUE_BITS);
  localparam int StepW = $clog2(VALUE_BITS);

  logic [3:0]            radix;
  logic [3:0]            base;
  logic [VALUE_BITS-1:0] mag;
  logic [VALUE_BITS-1:0] mag_next;
  logic [VALUE_BITS-1:0] mag_load;
  logic [3:0]            rem;
  logic [4:0]            trial;
  logic [4:0]            diff;
  logic                  qbit;
  logic [3:0]            rem_next;
  logic [StepW-1:0]      step;
  logic [CntW-1:0]       cnt;
  logic [CntW-1:0]       cnt_dec;
  logic                  neg;
  logic [3:0]            rd_data;
  logic [3:0]            stack [VALUE_BITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= rdc_pkg::RADIX_RESET;
    end else if (cfg_wr_en) begin
      radix <= cfg_wr_data;
    end
  end

  assign base     = rdc_pkg::eff_base(radix);
  assign mag_load = VALUE_BITS'({{VALUE_BITS{1'b0}}, value});

  // one restoring-division step per cycle
  assign trial    = {rem, mag[VALUE_BITS-1]};
  assign qbit     = (trial >= {1'b0, base});
  assign diff     = trial - {1'b0, base};
  assign rem_next = qbit ? diff[3:0] : trial[3:0];
  assign mag_next = {mag[VALUE_BITS-2:0], qbit};
  assign cnt_dec  = cnt - CntW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      step <= '0;
      rem  <= '0;
      neg  <= 1'b0;
    end else if (cmd.load) begin
      cnt  <= '0;
      step <= '0;
      rem  <= '0;
      neg  <= value[31];
    end else if (cmd.div_step) begin
      if (stat.step_last) begin
        step <= '0;
        rem  <= '0;
        cnt  <= cnt + CntW'(1);
      end else begin
        step <= step + StepW'(1);
        rem  <= rem_next;
      end
    end else if (cmd.pop) begin
      cnt <= cnt_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mag <= mag_load;
    end else if (cmd.div_step) begin
      mag <= mag_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_step && stat.step_last) begin
      stack[cnt[IdxW-1:0]] <= rem_next;
    end
    if (cmd.pop) begin
      rd_data <= stack[cnt_dec[IdxW-1:0]];
    end
  end

  assign stat.in_neg    = value[31];
  assign stat.neg       = neg;
  assign stat.step_last = (step == StepW'(VALUE_BITS - 1));
  assign stat.quo_zero  = (mag_next == '0);
  assign stat.empty     = (cnt == '0);

  assign digit      = neg ? 4'd0 : rd_data;
  assign last_digit = neg || (cnt == '0);
  assign invalid    = neg;

endmodule

// ===== design/radix_digit_converter_unit.sv =====
// Radix digit converter top level: controller plus datapath.
// Sequence: accept the item, then one pass of the bit-serial divider per digit until the
// quotient is zero, then per digit a stack read and a present state.
// One item at a time; a negative item skips the divider: accept, then present.
// Output stalls hold the present state until the receiver takes the digit.
// Reset (rst, synchronous): controller idle, digit stack empty, radix = 10.
module radix_digit_converter_unit #(
  parameter int VALUE_BITS = 31
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [3:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  digit,
  output logic        last_digit,
  output logic        invalid
);

  rdc_pkg::dp_cmd_t  cmd;
  rdc_pkg::dp_stat_t stat;

  rdc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  rdc_datapath #(
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .value       (value),
    .cmd         (cmd),
    .stat        (stat),
    .digit       (digit),
    .last_digit  (last_digit),
    .invalid     (invalid)
  );

`ifndef SYNTHESIS
  a_invalid_single : assert property (@(posedge clk) disable iff (rst)
    out_valid && invalid |-> digit == 4'd0 && last_digit)
    else $error("invalid item must be a single zero digit");

  a_no_overlap : assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |-> !out_valid)
    else $error("item accepted while a digit is pending");

  a_digit_range : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> digit <= 4'd9)
    else $error("digit out of range");

  a_cmd_exclusive : assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.div_step, cmd.pop}))
    else $error("conflicting datapath commands");
`endif

endmodule

// ===== test/rdc_digit_checker.sv =====
// Scoreboard for the radix digit converter: tracks the radix register, predicts the
// digit sequence of every accepted item and compares each accepted result with it.
// Depends on rdc_pkg (RADIX_RESET) only.
module rdc_digit_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [3:0]  cfg_wr_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [31:0] value,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [3:0]  digit,
  input  logic        last_digit,
  input  logic        invalid,
  output int          mismatches,
  output int          outstanding,
  output int          results_seen
);

  typedef struct packed {
    logic [3:0] digit;
    logic       last;
    logic       inv;
  } digit_result_t;

  logic [3:0]    radix_reg;
  digit_result_t expected_digits[$];

  // Digits come out most significant first; negative items give one flagged result.
  task automatic queue_digits_of(input logic [31:0] v);
    int unsigned   base;
    int unsigned   mag;
    logic [3:0]    lsd_first[$];
    digit_result_t r;
    if (radix_reg >= 4'd2 && radix_reg <= 4'd9) begin
      base = {28'd0, radix_reg};
    end else begin
      base = 10;
    end
    if (v[31]) begin
      r.digit = 4'd0;
      r.last  = 1'b1;
      r.inv   = 1'b1;
      expected_digits.push_back(r);
      return;
    end
    mag = {1'b0, v[30:0]};
    do begin
      lsd_first.push_back(4'(mag % base));
      mag = mag / base;
    end while (mag != 0);
    while (lsd_first.size() > 0) begin
      r.digit = lsd_first.pop_back();
      r.last  = (lsd_first.size() == 0);
      r.inv   = 1'b0;
      expected_digits.push_back(r);
    end
  endtask

  initial begin
    mismatches   = 0;
    outstanding  = 0;
    results_seen = 0;
    radix_reg    = rdc_pkg::RADIX_RESET;
  end

  always @(posedge clk) begin
    digit_result_t e;
    if (rst) begin
      radix_reg = rdc_pkg::RADIX_RESET;
      expected_digits.delete();
    end else begin
      if (cfg_wr_en) begin
        radix_reg = cfg_wr_data;
      end
      if (in_valid && !in_stall) begin
        queue_digits_of(value);
      end
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_digits.size() == 0) begin
          $error("unexpected result: digit %0d last_digit %0b invalid %0b",
                 digit, last_digit, invalid);
          mismatches++;
        end else begin
          e = expected_digits.pop_front();
          if (digit !== e.digit) begin
            $error("digit: expected %0d, got %0d", e.digit, digit);
            mismatches++;
          end
          if (last_digit !== e.last) begin
            $error("last_digit: expected %0b, got %0b", e.last, last_digit);
            mismatches++;
          end
          if (invalid !== e.inv) begin
            $error("invalid: expected %0b, got %0b", e.inv, invalid);
            mismatches++;
          end
        end
      end
    end
    outstanding = expected_digits.size();
  end

endmodule

// ===== test/radix_digit_converter_unit_tb.sv =====
// Testbench top for radix_digit_converter_unit: clock, reset, item and radix stimulus,
// receiver stalls, watchdog and verdict. Checking is done by rdc_digit_checker.
// Depends on rdc_pkg, radix_digit_converter_unit and rdc_digit_checker.
module radix_digit_converter_unit_tb;

  localparam logic [31:0] NEG_ONE     = 32'hFFFF_FFFF;
  localparam logic [31:0] MAX_POS     = 32'h7FFF_FFFF;
  localparam int          QUIET_LIMIT = 5000;
  localparam int          HOLD_CYCLES = 400;
  localparam int          HOLD_AT     = 70;
  localparam int          PHASES      = 16;
  localparam int          PER_PHASE   = 13;

  logic        clk;
  logic        rst;
  logic        cfg_wr_en;
  logic [3:0]  cfg_wr_data;
  logic        in_valid;
  logic        in_stall;
  logic [31:0] value;
  logic        out_valid;
  logic        out_stall;
  logic [3:0]  digit;
  logic        last_digit;
  logic        invalid;

  int mismatches;
  int outstanding;
  int results_seen;
  int items_sent;
  int invalid_sent;
  int radix_writes;
  int burst_left;
  int quiet_cycles;

  radix_digit_converter_unit dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .value       (value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .digit       (digit),
    .last_digit  (last_digit),
    .invalid     (invalid)
  );

  rdc_digit_checker checker_i (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .value        (value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .digit        (digit),
    .last_digit   (last_digit),
    .invalid      (invalid),
    .mismatches   (mismatches),
    .outstanding  (outstanding),
    .results_seen (results_seen)
  );

  always #5 clk = ~clk;

  // Sender: bursts of random length, random gaps, valid held while stalled.
  task automatic send_item(input logic [31:0] v);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
    end
    in_valid <= 1'b1;
    value    <= v;
    do @(posedge clk); while (in_stall);
    burst_left--;
    items_sent++;
    if (v[31]) invalid_sent++;
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_radix(input logic [3:0] r);
    drain_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= r;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    burst_left = 0;
    radix_writes++;
  endtask

  function automatic logic [31:0] random_value();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 8) return NEG_ONE;
    if (pick < 12) return {1'b1, 31'($urandom)};
    if (pick < 22) return 32'($urandom_range(0, 20));
    if (pick < 30) return MAX_POS >> $urandom_range(0, 30);
    return {1'b0, 31'($urandom)} >> $urandom_range(0, 30);
  endfunction

  // Receiver: stall pattern rotates through four modes, plus one long hold-off.
  initial begin
    int  cyc;
    bit  held;
    out_stall = 1'b0;
    cyc       = 0;
    held      = 1'b0;
    forever begin
      @(negedge clk);
      cyc++;
      if (!held && items_sent >= HOLD_AT) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall <= 1'b0;
      end else begin
        case ((cyc / 300) % 4)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 9) < 7);
          default: out_stall <= ((cyc % 7) < 3);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Watchdog: no handshake for %0d cycles", QUIET_LIMIT);
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    logic [3:0] radix_plan [0:PHASES-1];
    radix_plan   = '{4'd0, 4'd15, 4'd1, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
                     4'd8, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd2, 4'd9};
    clk          = 1'b0;
    rst          = 1'b1;
    cfg_wr_en    = 1'b0;
    cfg_wr_data  = 4'd0;
    in_valid     = 1'b0;
    value        = 32'd0;
    items_sent   = 0;
    invalid_sent = 0;
    radix_writes = 0;
    burst_left   = 0;
    quiet_cycles = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: reset radix (10) first, then both ends of the legal base range.
    send_item(32'd0);
    send_item(32'd1);
    send_item(32'd9);
    send_item(32'd10);
    send_item(32'd99);
    send_item(32'd100);
    send_item(32'd1_000_000_000);
    send_item(MAX_POS);
    send_item(NEG_ONE);
    send_item(32'h8000_0000);
    send_item(32'hFFFF_FFFE);
    send_item(32'h1234_5678);
    write_radix(4'd2);
    send_item(32'd0);
    send_item(32'd1);
    send_item(32'd2);
    send_item(MAX_POS);
    send_item(32'h5555_5555);
    send_item(NEG_ONE);
    write_radix(4'd9);
    send_item(32'd8);
    send_item(32'd9);
    send_item(32'd80);
    send_item(MAX_POS);

    for (int p = 0; p < PHASES; p++) begin
      write_radix(radix_plan[p]);
      for (int i = 0; i < PER_PHASE; i++) begin
        send_item(random_value());
      end
    end

    drain_results();
    repeat (50) @(negedge clk);

    $display("Covered %0d items (%0d negative) over %0d radix writes, codes 0..15.",
             items_sent, invalid_sent, radix_writes);
    $display("Checked %0d digit results under bursty input and patterned output stalls.",
             results_seen);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
